// ----- rtl/bds_pkg.sv -----
// Shared types, constants and helpers for the 3x3 box downsampler.
package bds_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int ROW_W         = 12;
   localparam int CH_W          = 8;
   localparam int SUM_W         = 12;
   localparam int NUM_CH        = 3;
   localparam int CFG_W         = 13;
   localparam int CSR_IDX_W     = 2;
   localparam int LINE_W        = SUM_W * NUM_CH;
   localparam int PIX_W         = CH_W * NUM_CH;

   // 2^16 / 9 rounded up; exact for all sums below 4096
   localparam logic [12:0] DIV9_RECIP = 13'd7282;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic [1:0] weight_type;

   typedef struct packed {
      logic       first_col;
      logic       first_row;
      weight_type hw;
      weight_type vw;
   } lane_ctrl_type;

   // weight of a sample: the last column or row is repeated to fill the block
   function automatic weight_type block_weight(input logic last, input logic [1:0] pos);
      weight_type w;
      w = last ? weight_type'(2'd3 - pos) : weight_type'(2'd1);
      return w;
   endfunction

   function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
      logic [24:0] p;
      p = 25'(x) * 25'(DIV9_RECIP);
      return p[23:16];
   endfunction

endpackage

// ----- rtl/box_downsample_3x3_rgb.sv -----
// 3x3 box downsampler top level: position tracking, line store, result register.
//
// Pixels enter in raster order on the req_ channel, one transaction per pixel,
// and the block emits the one-third-size frame on the rsp_ channel. Each result
// is the per-channel truncated mean of a 3x3 block; a short last column or row
// is repeated to fill its block. rsp_frame_done marks the last output pixel.
// Frame size is set through the csr_ port (index 0 width, index 1 height);
// a write to either restarts the frame at pixel (0,0). csr_ready is always high.
// A taken pixel is registered in the work stage; one that completes a block
// moves on to the result register. Throughput: one pixel per cycle while
// req_stall is low, set by the line store, whose read for a block column is
// issued as the pixel is taken and whose write-back happens as it leaves the
// work stage; a same-address write and read are forwarded around the RAM.
// Reset returns the size to 1x1 and the position to zero; the line store needs
// no clearing pass, since every column entry is written on the first row of a
// block row before it is used. When rsp_stall holds a result, pixels that
// complete no block keep flowing; the next pixel that completes one waits in
// the work stage and holds req_stall high until the held result is taken.
module box_downsample_3x3_rgb #(
   parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bds_pkg::CH_W-1:0]        req_in_red,
   input  logic [bds_pkg::CH_W-1:0]        req_in_green,
   input  logic [bds_pkg::CH_W-1:0]        req_in_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bds_pkg::CH_W-1:0]        rsp_out_red,
   output logic [bds_pkg::CH_W-1:0]        rsp_out_green,
   output logic [bds_pkg::CH_W-1:0]        rsp_out_blue,
   output logic                            rsp_frame_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bds_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int LINE_DEPTH = (MAX_WIDTH + 2) / 3;
   localparam int BW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // frame geometry
   logic [CW-1:0]                w_last_ff, w_last_in;
   logic [bds_pkg::ROW_W-1:0]    h_last_ff, h_last_in;
   logic [31:0]                  w_req, h_req;

   // position of the next input pixel
   logic [CW-1:0]                col_ff, col_in;
   logic [1:0]                   cmod_ff, cmod_in;
   logic [BW-1:0]                bx_ff, bx_in;
   logic [bds_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [1:0]                   rmod_ff, rmod_in;

   // work stage
   logic                         s1_valid_ff, s1_valid_in;
   logic [bds_pkg::PIX_W-1:0]    s1_pix_ff;
   bds_pkg::lane_ctrl_type       s1_ctrl_ff, ctrl_in;
   logic                         s1_col_end_ff, s1_res_ff, s1_done_ff;
   logic                         col_end_in, res_in, done_in;
   logic [BW-1:0]                s1_bx_ff;
   logic                         s1_go;

   logic                         last_col, last_row;
   logic                         req_accept, rsp_accept, csr_write;

   // line store and forwarding
   logic                         ram_we;
   logic [bds_pkg::LINE_W-1:0]   ram_rd_data, col_partial;
   logic                         byp_ff, byp_in;
   logic [bds_pkg::LINE_W-1:0]   byp_data_ff;

   logic [bds_pkg::LINE_W-1:0]   row_partial_ff, row_sum, col_sum;
   logic [bds_pkg::PIX_W-1:0]    avg;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bds_pkg::PIX_W-1:0]    rsp_pix_ff;
   logic                         rsp_done_ff;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   assign s1_go     = s1_valid_ff && (!s1_res_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;

   // clamp the written size to the supported range
   always_comb begin
      w_req = 32'(csr_wdata);
      h_req = 32'(csr_wdata);
      if (w_req == 32'd0) begin
         w_req = 32'd1;
      end else if (w_req > 32'(MAX_WIDTH)) begin
         w_req = 32'(MAX_WIDTH);
      end
      if (h_req == 32'd0) begin
         h_req = 32'd1;
      end else if (h_req > 32'(bds_pkg::MAX_HEIGHT)) begin
         h_req = 32'(bds_pkg::MAX_HEIGHT);
      end
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_write) begin
         unique case (csr_index)
            bds_pkg::CSR_FRAME_WIDTH:  w_last_in = CW'(w_req - 32'd1);
            bds_pkg::CSR_FRAME_HEIGHT: h_last_in = bds_pkg::ROW_W'(h_req - 32'd1);
            default: ;
         endcase
      end
   end

   // block flags for the incoming pixel and the next position
   always_comb begin
      last_col   = (col_ff == w_last_ff);
      last_row   = (row_ff == h_last_ff);
      ctrl_in.first_col = (cmod_ff == 2'd0);
      ctrl_in.first_row = (rmod_ff == 2'd0);
      ctrl_in.hw        = bds_pkg::block_weight(last_col, cmod_ff);
      ctrl_in.vw        = bds_pkg::block_weight(last_row, rmod_ff);
      col_end_in = (cmod_ff == 2'd2) || last_col;
      res_in     = col_end_in && ((rmod_ff == 2'd2) || last_row);
      done_in    = last_col && last_row;

      col_in  = col_ff;
      cmod_in = cmod_ff;
      bx_in   = bx_ff;
      row_in  = row_ff;
      rmod_in = rmod_ff;
      priority if (csr_write && ((csr_index == bds_pkg::CSR_FRAME_WIDTH) ||
                                 (csr_index == bds_pkg::CSR_FRAME_HEIGHT))) begin
         col_in  = '0;
         cmod_in = '0;
         bx_in   = '0;
         row_in  = '0;
         rmod_in = '0;
      end else if (req_accept) begin
         if (last_col) begin
            col_in  = '0;
            cmod_in = '0;
            bx_in   = '0;
            row_in  = last_row ? '0 : row_ff + 1'b1;
            rmod_in = (last_row || rmod_ff == 2'd2) ? 2'd0 : rmod_ff + 2'd1;
         end else begin
            col_in  = col_ff + 1'b1;
            cmod_in = (cmod_ff == 2'd2) ? 2'd0 : cmod_ff + 2'd1;
            bx_in   = (cmod_ff == 2'd2) ? bx_ff + 1'b1 : bx_ff;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_res_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign ram_we      = s1_go && s1_col_end_ff;
   // write-back landing on the entry read in the same cycle
   assign byp_in      = ram_we && (s1_bx_ff == bx_ff);
   assign col_partial = byp_ff ? byp_data_ff : ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff    <= '0;
         h_last_ff    <= '0;
         col_ff       <= '0;
         cmod_ff      <= '0;
         bx_ff        <= '0;
         row_ff       <= '0;
         rmod_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_last_ff    <= w_last_in;
         h_last_ff    <= h_last_in;
         col_ff       <= col_in;
         cmod_ff      <= cmod_in;
         bx_ff        <= bx_in;
         row_ff       <= row_in;
         rmod_ff      <= rmod_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff     <= {req_in_red, req_in_green, req_in_blue};
         s1_ctrl_ff    <= ctrl_in;
         s1_col_end_ff <= col_end_in;
         s1_res_ff     <= res_in;
         s1_done_ff    <= done_in;
         s1_bx_ff      <= bx_ff;
         byp_ff        <= byp_in;
         byp_data_ff   <= col_sum;
      end
      if (s1_go) begin
         row_partial_ff <= row_sum;
      end
      if (s1_go && s1_res_ff) begin
         rsp_pix_ff  <= avg;
         rsp_done_ff <= s1_done_ff;
      end
   end

   bds_ram #(
      .WIDTH (bds_pkg::LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_bx_ff),
      .wr_data (col_sum),
      .rd_en   (req_accept),
      .rd_addr (bx_ff),
      .rd_data (ram_rd_data)
   );

   for (genvar ch = 0; ch < bds_pkg::NUM_CH; ch++) begin : g_lane
      localparam int SH = bds_pkg::SUM_W * (bds_pkg::NUM_CH - ch) - 1;
      localparam int PH = bds_pkg::CH_W * (bds_pkg::NUM_CH - ch) - 1;
      bds_lane u_lane (
         .ctrl        (s1_ctrl_ff),
         .pix         (s1_pix_ff[PH -: bds_pkg::CH_W]),
         .row_partial (row_partial_ff[SH -: bds_pkg::SUM_W]),
         .col_partial (col_partial[SH -: bds_pkg::SUM_W]),
         .row_sum     (row_sum[SH -: bds_pkg::SUM_W]),
         .col_sum     (col_sum[SH -: bds_pkg::SUM_W]),
         .avg         (avg[PH -: bds_pkg::CH_W])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_pix_ff[3*bds_pkg::CH_W-1 -: bds_pkg::CH_W];
   assign rsp_out_green  = rsp_pix_ff[2*bds_pkg::CH_W-1 -: bds_pkg::CH_W];
   assign rsp_out_blue   = rsp_pix_ff[bds_pkg::CH_W-1 -: bds_pkg::CH_W];
   assign rsp_frame_done = rsp_done_ff;

endmodule

// ----- rtl/bds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bds_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1366,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bds_lane.sv -----
// One color channel: horizontal sum, vertical sum and divide by nine.
module bds_lane (
   input  bds_pkg::lane_ctrl_type           ctrl,
   input  logic [bds_pkg::CH_W-1:0]         pix,
   input  logic [bds_pkg::SUM_W-1:0]        row_partial,
   input  logic [bds_pkg::SUM_W-1:0]        col_partial,
   output logic [bds_pkg::SUM_W-1:0]        row_sum,
   output logic [bds_pkg::SUM_W-1:0]        col_sum,
   output logic [bds_pkg::CH_W-1:0]         avg
);

   logic [bds_pkg::SUM_W-1:0] pix_w;
   logic [bds_pkg::SUM_W-1:0] row_w;

   always_comb begin
      pix_w   = bds_pkg::SUM_W'(pix) * bds_pkg::SUM_W'(ctrl.hw);
      row_sum = (ctrl.first_col ? '0 : row_partial) + pix_w;
      row_w   = row_sum * bds_pkg::SUM_W'(ctrl.vw);
      col_sum = (ctrl.first_row ? '0 : col_partial) + row_w;
      avg     = bds_pkg::div9(col_sum);
   end

endmodule

// ----- rtl/bds_checker.sv -----
// Port-level checks for the 3x3 box downsampler, bound to the top level.
module bds_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bds_pkg::CH_W-1:0]      rsp_out_red,
   input logic [bds_pkg::CH_W-1:0]      rsp_out_green,
   input logic [bds_pkg::CH_W-1:0]      rsp_out_blue,
   input logic                          rsp_frame_done
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red) &&
         $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_frame_done))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the input side backs up only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // a new result needs a pixel taken earlier that passed through the work stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a transaction");

endmodule

bind box_downsample_3x3_rgb bds_checker u_checker (.*);

// ----- tb/sv/box_downsample_3x3_rgb_test.sv -----
// Self-checking testbench for the 3x3 RGB box downsampler: random traffic, scoreboard.
module box_downsample_3x3_rgb_test;

   localparam int LINE_DEPTH    = (bds_pkg::MAX_WIDTH_DEF + 2) / 3;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 250;
   localparam int PHASE_PIXELS  = 370;
   localparam logic [bds_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [bds_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [bds_pkg::CFG_W-1:0] SIZE_ALL_ONES = '1;
   localparam logic [63:0] MASK36 = 64'hF_FFFF_FFFF;
   localparam logic [63:0] MASK12 = 64'hFFF;

   typedef struct packed {
      logic [bds_pkg::CH_W-1:0] red;
      logic [bds_pkg::CH_W-1:0] green;
      logic [bds_pkg::CH_W-1:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [bds_pkg::CH_W-1:0] red;
      logic [bds_pkg::CH_W-1:0] green;
      logic [bds_pkg::CH_W-1:0] blue;
      logic                     frame_done;
   } down_pixel_type;

   typedef struct packed {
      logic [bds_pkg::CSR_IDX_W-1:0] index;
      logic [bds_pkg::CFG_W-1:0]     data;
   } size_write_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [bds_pkg::CH_W-1:0]      req_in_red = '0, req_in_green = '0, req_in_blue = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [bds_pkg::CH_W-1:0]      rsp_out_red, rsp_out_green, rsp_out_blue;
   logic                          rsp_frame_done;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [bds_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bds_pkg::CFG_W-1:0]     csr_wdata = '0;

   rgb_pixel_type  pixel_queue[$];
   down_pixel_type expected_pixels[$];
   size_write_type size_writes[$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_plan[4]  = '{0, 86, 0, 13};
   int unsigned stall_plan[4] = '{0, 0, 86, 13};

   // downscaler state mirrored on the testbench side
   logic [35:0]               block_col_sums[LINE_DEPTH];
   logic [35:0]               row_sum = '0;
   int unsigned               col_pos = 0, row_pos = 0;
   logic [bds_pkg::CFG_W-1:0] width_reg = 13'd1, height_reg = 13'd1;

   box_downsample_3x3_rgb u_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int unsigned clamp_size(input logic [bds_pkg::CFG_W-1:0] v,
                                              input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return 32'(v);
   endfunction

   function automatic void apply_size_write(input logic [bds_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [bds_pkg::CFG_W-1:0] data);
      if (idx == bds_pkg::CSR_FRAME_WIDTH) width_reg = data;
      else if (idx == bds_pkg::CSR_FRAME_HEIGHT) height_reg = data;
      else return;
      // any size write restarts the frame
      col_pos = 0;
      row_pos = 0;
      row_sum = '0;
   endfunction

   function automatic void downscale_pixel(input rgb_pixel_type px);
      int unsigned w, h, c, r, bx;
      logic [63:0] hw, vw, pix, row, col;
      down_pixel_type res;
      w = clamp_size(width_reg, bds_pkg::MAX_WIDTH_DEF);
      h = clamp_size(height_reg, bds_pkg::MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      if (c >= w || r >= h) begin
         c = 0;
         r = 0;
         row_sum = '0;
      end
      // last column / row is repeated to fill the block
      hw = (c == w - 1) ? 64'(3 - c % 3) : 64'd1;
      vw = (r == h - 1) ? 64'(3 - r % 3) : 64'd1;
      pix = {32'd0, px.red, 4'd0, px.green, 4'd0, px.blue};
      row = ((c % 3 == 0) ? pix * hw : {28'd0, row_sum} + pix * hw) & MASK36;
      row_sum = row[35:0];
      if (c % 3 == 2 || c == w - 1) begin
         bx = c / 3;
         col = ((r % 3 == 0) ? row * vw : {28'd0, block_col_sums[bx]} + row * vw) & MASK36;
         block_col_sums[bx] = col[35:0];
         if (r % 3 == 2 || r == h - 1) begin
            res.red        = bds_pkg::CH_W'(((col >> 24) & MASK12) / 9);
            res.green      = bds_pkg::CH_W'(((col >> 12) & MASK12) / 9);
            res.blue       = bds_pkg::CH_W'((col & MASK12) / 9);
            res.frame_done = (r == h - 1 && c == w - 1);
            expected_pixels.insert(expected_pixels.size(), res);
         end
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [bds_pkg::CH_W-1:0] want,
                                       input logic [bds_pkg::CH_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // pixel driver: payload held while stalled, valid decided without looking at stall
   always @(posedge clock) begin : drive_pixels
      rgb_pixel_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall)
            downscale_pixel({req_in_red, req_in_green, req_in_blue});
         if (!(req_valid && req_stall)) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pixel_queue.pop_front();
               req_valid    <= 1'b1;
               req_in_red   <= nxt.red;
               req_in_green <= nxt.green;
               req_in_blue  <= nxt.blue;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : drive_sizes
      size_write_type sw;
      if (!reset) begin
         if (csr_valid && csr_ready) apply_size_write(csr_index, csr_wdata);
         if (!csr_valid || csr_ready) begin
            if (size_writes.size() != 0) begin
               sw = size_writes.pop_front();
               csr_valid <= 1'b1;
               csr_index <= sw.index;
               csr_wdata <= sw.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : check_results
      down_pixel_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_done};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.red, got.red);
               check_field("green", want.green, got.green);
               check_field("blue", want.blue, got.blue);
               check_field("frame_done", bds_pkg::CH_W'(want.frame_done),
                           bds_pkg::CH_W'(got.frame_done));
            end
         end
      end
   end

   // receiver stall: random, or a long hold counted down in cycles
   always @(posedge clock) begin : stall_receiver
      if (!reset) begin
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic settle();
      while (pixel_queue.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [bds_pkg::CSR_IDX_W-1:0] idx,
                             input logic [bds_pkg::CFG_W-1:0] data);
      size_write_type sw;
      sw = {idx, data};
      size_writes.insert(size_writes.size(), sw);
      while (size_writes.size() != 0 || csr_valid) @(negedge clock);
   endtask

   task automatic set_size(input logic [bds_pkg::CFG_W-1:0] w,
                           input logic [bds_pkg::CFG_W-1:0] h);
      write_size(bds_pkg::CSR_FRAME_WIDTH, w);
      write_size(bds_pkg::CSR_FRAME_HEIGHT, h);
   endtask

   task automatic queue_rgb(input logic [bds_pkg::CH_W-1:0] r,
                            input logic [bds_pkg::CH_W-1:0] g,
                            input logic [bds_pkg::CH_W-1:0] b);
      rgb_pixel_type px;
      px = {r, g, b};
      pixel_queue.insert(pixel_queue.size(), px);
   endtask

   function automatic logic [bds_pkg::CH_W-1:0] pick_level(input bit extreme);
      if (extreme) return $urandom_range(1) ? 8'hFF : 8'h00;
      return bds_pkg::CH_W'($urandom_range(255));
   endfunction

   task automatic queue_pixels(input int unsigned count, input bit extreme);
      repeat (count) queue_rgb(pick_level(extreme), pick_level(extreme), pick_level(extreme));
   endtask

   initial begin : run_stimulus
      int unsigned w, h, n, frame_px, phase_count, sel;
      wait (reset == 1'b0);
      @(negedge clock);

      // out of reset the frame is 1x1: each pixel is its own block
      queue_rgb(8'hFF, 8'h00, 8'hFF);
      queue_rgb(8'h00, 8'hFF, 8'h00);
      settle();
      set_size(13'd0, 13'd0);
      queue_rgb(8'd170, 8'd85, 8'd1);
      settle();
      // short last column and row, each counted twice
      set_size(13'd2, 13'd2);
      repeat (4) queue_rgb(8'hFF, 8'hFF, 8'hFF);
      settle();
      // last column alone in its block, counted three times
      set_size(13'd4, 13'd1);
      queue_rgb(8'd1, 8'd2, 8'd3);
      queue_rgb(8'hFF, 8'hFF, 8'hFF);
      queue_rgb(8'h00, 8'h00, 8'h00);
      queue_rgb(8'd200, 8'd100, 8'd50);
      settle();
      // writes to unused indexes leave the frame position alone
      set_size(13'd3, 13'd1);
      queue_rgb(8'd10, 8'd20, 8'd30);
      queue_rgb(8'd40, 8'd50, 8'd60);
      settle();
      write_size(CSR_SPARE_2, SIZE_ALL_ONES);
      write_size(CSR_SPARE_3, SIZE_ALL_ONES);
      queue_rgb(8'd70, 8'd80, 8'd90);
      settle();
      set_size(SIZE_ALL_ONES, 13'd1);
      queue_pixels(3, 1'b0);
      settle();
      set_size(13'd1, SIZE_ALL_ONES);
      queue_pixels(3, 1'b0);
      settle();

      // receiver holds off while the sender keeps pushing
      set_size(13'd3, 13'd1);
      hold_request = 1'b1;
      queue_pixels(60, 1'b0);
      settle();

      foreach (send_plan[p]) begin
         send_idle_pct = send_plan[p];
         stall_pct = stall_plan[p];
         phase_count = 0;
         while (phase_count < PHASE_PIXELS) begin
            settle();
            sel = $urandom_range(19);
            if (sel == 0) begin
               w = $urandom_range(600, 8191);
               h = $urandom_range(1, 3);
            end else if (sel == 1) begin
               w = $urandom_range(1, 3);
               h = $urandom_range(600, 8191);
            end else if (sel == 2) begin
               w = $urandom_range(1) ? 0 : $urandom_range(1, 6);
               h = $urandom_range(1) ? 0 : $urandom_range(1, 6);
            end else if (sel < 6) begin
               w = $urandom_range(1, 30);
               h = $urandom_range(1, 30);
            end else begin
               w = $urandom_range(1, 12);
               h = $urandom_range(1, 12);
            end
            set_size(bds_pkg::CFG_W'(w), bds_pkg::CFG_W'(h));
            if ($urandom_range(7) == 0)
               write_size($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3,
                          bds_pkg::CFG_W'($urandom_range(8191)));
            frame_px = clamp_size(bds_pkg::CFG_W'(w), bds_pkg::MAX_WIDTH_DEF) *
                       clamp_size(bds_pkg::CFG_W'(h), bds_pkg::MAX_HEIGHT);
            sel = $urandom_range(9);
            if (frame_px > 240) n = $urandom_range(9, 120);
            else if (sel < 2) n = $urandom_range(1, frame_px);
            else if (sel == 2) n = 2 * frame_px + $urandom_range(frame_px);
            else n = frame_px * $urandom_range(1, 2);
            queue_pixels(n, $urandom_range(5) == 0);
            phase_count += n;
         end
      end

      settle();
      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
